FILE: src/metb_pkg.sv
// ----------------------------------------------------------------------------
// metb_pkg
// Shared types and constants of the mesh edge table builder.
// ----------------------------------------------------------------------------
package metb_pkg;

    // Operation codes carried on s_tuser.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Status codes carried on m_tuser.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TRI_LIM  = 2'd2;
    localparam logic [1:0] ST_NOT_WRIT = 2'd3;

    // Fixed field widths and stream widths.
    localparam int VX_W     = 10;
    localparam int PICK_W   = 12;
    localparam int EDGE_W   = 13;
    localparam int TRI_W    = 14;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 104;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture an input transfer
        logic clear_start; // restart counters and head sweep
        logic sweep;       // clear one chain head entry
        logic head_chk;    // take chain head, issue first edge read
        logic edge_adv;    // step to the next chain entry
        logic edge_hit;    // keep the matched entry
        logic append;      // append a missing edge
        logic update;      // update the triangle slot of a found edge
        logic finish;      // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       lim;
        logic       head_zero;
        logic       match;
        logic       next_zero;
        logic       last_edge;
        logic       sweep_done;
        logic       out_free;
    } sts_t;

endpackage

FILE: src/metb_ram.sv
// ----------------------------------------------------------------------------
// metb_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module metb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/metb_ctrl.sv
// ----------------------------------------------------------------------------
// metb_ctrl
// Controller of the edge table builder: sequences sweeps, chain walks,
// appends, updates and result delivery.
// ----------------------------------------------------------------------------
module metb_ctrl import metb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DISP   = 10'b0000000010,
        S_SWEEP  = 10'b0000000100,
        S_HEAD   = 10'b0000001000,
        S_HCHK   = 10'b0000010000,
        S_ECHK   = 10'b0000100000,
        S_APPEND = 10'b0001000000,
        S_UPDATE = 10'b0010000000,
        S_READ   = 10'b0100000000,
        S_FINISH = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   reply_reg, reply_next;

    // State register; reset starts with a head sweep that sends no result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
            reply_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        reply_next = reply_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (sts.op)
                    OP_CLEAR: begin
                        cmd.clear_start = 1'b1;
                        reply_next      = 1'b1;
                        state_next      = S_SWEEP;
                    end
                    OP_ADD:  state_next = sts.lim ? S_FINISH : S_HEAD;
                    OP_READ: state_next = S_READ;
                    default: state_next = S_FINISH;
                endcase
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_done) begin
                    state_next = reply_reg ? S_FINISH : S_IDLE;
                end
            end
            S_HEAD: state_next = S_HCHK;
            S_HCHK: begin
                cmd.head_chk = 1'b1;
                state_next   = sts.head_zero ? S_APPEND : S_ECHK;
            end
            S_ECHK: begin
                if (sts.match) begin
                    cmd.edge_hit = 1'b1;
                    state_next   = S_UPDATE;
                end else if (sts.next_zero) begin
                    state_next = S_APPEND;
                end else begin
                    cmd.edge_adv = 1'b1;
                end
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                state_next = sts.last_edge ? S_FINISH : S_HEAD;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = sts.last_edge ? S_FINISH : S_HEAD;
            end
            S_READ: state_next = S_FINISH;
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    reply_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: src/metb_dp.sv
// ----------------------------------------------------------------------------
// metb_dp
// Datapath of the edge table builder: chain head memory, edge memory,
// counters, edge key logic and the result register.
// ----------------------------------------------------------------------------
module metb_dp import metb_pkg::*; #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_EDGES     = 4096,
    parameter int MAX_TRIANGLES = 2048
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [1:0]          in_op,
    input  logic [S_DATA_W-1:0] in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [M_DATA_W-1:0] out_data,
    output logic [1:0]          out_status
);

    // Chains are keyed by the low bits of the smaller vertex; lookups compare
    // both vertices, so any consistent slot choice gives exact results.
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int SW  = (VW < VX_W) ? VW : VX_W;
    localparam int HD  = 1 << SW;
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int PW  = $clog2(3 * MAX_TRIANGLES + 1);
    localparam int TW  = PW + 1;
    localparam int ENW = EW + 2 * VX_W + 2 * TW;

    // Edge entry layout: {rev, fwd, hi, lo, next}; a slot of all ones is none.
    localparam int LO_B  = EW;
    localparam int HI_B  = EW + VX_W;
    localparam int FW_B  = EW + 2 * VX_W;
    localparam int RV_B  = FW_B + TW;

    localparam logic [PW-1:0] TRI_LIMIT = PW'(3 * MAX_TRIANGLES);
    localparam logic [CW-1:0] EDGE_CAP  = CW'(MAX_EDGES);

    // Captured input transfer.
    logic [1:0]        op_reg;
    logic [VX_W-1:0]   a_reg, b_reg, c_reg;
    logic [PICK_W-1:0] pick_reg;
    logic              lim_reg;

    // Table state and walk registers.
    logic [CW-1:0]  count_reg;
    logic [PW-1:0]  pos_reg;
    logic [SW-1:0]  sweep_reg;
    logic [1:0]     k_reg;
    logic [EW-1:0]  head_reg;
    logic [EW-1:0]  cur_reg;
    logic [ENW-1:0] ent_reg;
    logic           full_reg;
    logic [2:0]     mask_reg;
    logic [EDGE_W-1:0] res_reg [3];

    // Result register.
    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;
    logic [1:0]          stat_reg;

    // Memory ports.
    logic           head_we;
    logic [SW-1:0]  head_waddr;
    logic [EW-1:0]  head_wdata, head_rdata;
    logic           edge_we;
    logic [EW-1:0]  edge_waddr, edge_raddr;
    logic [ENW-1:0] edge_wdata, edge_rdata;

    // Edge key of the current edge.
    logic [VX_W-1:0] p_v, q_v, lo_v, hi_v;
    logic            fwd;
    logic [SW-1:0]   slot;
    logic [TW-1:0]   pos_slot;
    logic [EW-1:0]   new_e;
    logic [EW-1:0]   done_e;
    logic [EDGE_W-1:0] signed_e;
    logic            cap_full;
    logic            pick_ok;

    always_comb begin
        case (k_reg)
            2'd0:    begin p_v = a_reg; q_v = b_reg; end
            2'd1:    begin p_v = b_reg; q_v = c_reg; end
            default: begin p_v = c_reg; q_v = a_reg; end
        endcase
    end

    assign fwd      = (p_v <= q_v);
    assign lo_v     = fwd ? p_v : q_v;
    assign hi_v     = fwd ? q_v : p_v;
    assign slot     = SW'(lo_v);
    assign pos_slot = TW'(pos_reg);
    assign new_e    = EW'(count_reg);
    assign cap_full = (count_reg == EDGE_CAP);
    assign done_e   = cmd.append ? new_e : cur_reg;
    assign signed_e = fwd ? EDGE_W'(done_e) : (EDGE_W'(0) - EDGE_W'(done_e));
    assign pick_ok  = (32'(pick_reg) < 32'(count_reg));

    // Chain head memory: sweep clears it, appends relink it.
    assign head_we    = cmd.sweep || (cmd.append && !cap_full);
    assign head_waddr = cmd.sweep ? sweep_reg : slot;
    assign head_wdata = cmd.sweep ? '0 : new_e;

    metb_ram #(.WIDTH(EW), .DEPTH(HD)) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (slot),
        .rdata (head_rdata)
    );

    // Edge memory: read address follows the chain walk, else the read pick.
    always_comb begin
        if (cmd.head_chk) begin
            edge_raddr = head_rdata;
        end else if (cmd.edge_adv) begin
            edge_raddr = edge_rdata[EW-1:0];
        end else begin
            edge_raddr = EW'(pick_reg);
        end
    end

    always_comb begin
        edge_wdata = ent_reg;
        if (cmd.append) begin
            edge_wdata = {fwd ? {TW{1'b1}} : pos_slot, fwd ? pos_slot : {TW{1'b1}},
                          hi_v, lo_v, head_reg};
        end else if (fwd) begin
            edge_wdata[FW_B +: TW] = pos_slot;
        end else begin
            edge_wdata[RV_B +: TW] = pos_slot;
        end
    end

    assign edge_we    = cmd.update || (cmd.append && !cap_full);
    assign edge_waddr = cmd.append ? new_e : cur_reg;

    metb_ram #(.WIDTH(ENW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // Status toward the controller.
    assign sts.op         = op_reg;
    assign sts.lim        = lim_reg;
    assign sts.head_zero  = (head_rdata == '0);
    assign sts.match      = (edge_rdata[LO_B +: VX_W] == lo_v) &&
                            (edge_rdata[HI_B +: VX_W] == hi_v);
    assign sts.next_zero  = (edge_rdata[EW-1:0] == '0);
    assign sts.last_edge  = (k_reg == 2'd2);
    assign sts.sweep_done = (&sweep_reg);
    assign sts.out_free   = !valid_reg || out_ready;

    // Control state: counters, sweep pointer, result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(1);
            pos_reg   <= '0;
            sweep_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_start) begin
                count_reg <= CW'(1);
                pos_reg   <= '0;
                sweep_reg <= '0;
            end
            if (cmd.sweep) begin
                sweep_reg <= sweep_reg + SW'(1);
            end
            if (cmd.append && !cap_full) begin
                count_reg <= count_reg + CW'(1);
            end
            if ((cmd.append || cmd.update) && (k_reg == 2'd2)) begin
                pos_reg <= pos_reg + PW'(3);
            end
            if (cmd.finish) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Per-item registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            a_reg    <= in_data[0 +: VX_W];
            b_reg    <= in_data[VX_W +: VX_W];
            c_reg    <= in_data[2*VX_W +: VX_W];
            pick_reg <= in_data[3*VX_W +: PICK_W];
            lim_reg  <= (pos_reg >= TRI_LIMIT);
            k_reg    <= 2'd0;
            full_reg <= 1'b0;
            mask_reg <= 3'b000;
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= '0;
            end
        end
        if (cmd.head_chk) begin
            head_reg <= head_rdata;
            cur_reg  <= head_rdata;
        end
        if (cmd.edge_adv) begin
            cur_reg <= edge_rdata[EW-1:0];
        end
        if (cmd.edge_hit) begin
            ent_reg <= edge_rdata;
        end
        if (cmd.append && cap_full) begin
            full_reg <= 1'b1;
        end else if (cmd.append || cmd.update) begin
            res_reg[k_reg] <= signed_e;
            if (cmd.append) begin
                mask_reg <= mask_reg | (3'b001 << k_reg);
            end
        end
        if (cmd.append || cmd.update) begin
            k_reg <= k_reg + 2'd1;
        end
    end

    // Result formatting.
    logic [M_DATA_W-1:0] data_next;
    logic [1:0]          stat_next;
    logic [TRI_W-1:0]    fw_out, rv_out;
    logic [TW-1:0]       fw_f, rv_f;

    assign fw_f   = edge_rdata[FW_B +: TW];
    assign rv_f   = edge_rdata[RV_B +: TW];
    assign fw_out = (fw_f == {TW{1'b1}}) ? {TRI_W{1'b1}} : TRI_W'(fw_f);
    assign rv_out = (rv_f == {TW{1'b1}}) ? {TRI_W{1'b1}} : TRI_W'(rv_f);

    always_comb begin
        data_next = '0;
        stat_next = ST_OK;
        data_next[90 +: EDGE_W] = EDGE_W'(count_reg);
        case (op_reg)
            OP_ADD: begin
                if (lim_reg) begin
                    stat_next = ST_TRI_LIM;
                end else begin
                    data_next[0 +: EDGE_W]  = res_reg[0];
                    data_next[13 +: EDGE_W] = res_reg[1];
                    data_next[26 +: EDGE_W] = res_reg[2];
                    data_next[39 +: 3]      = mask_reg;
                    stat_next = full_reg ? ST_FULL : ST_OK;
                end
            end
            OP_READ: begin
                if (!pick_ok) begin
                    stat_next = ST_NOT_WRIT;
                end else if (pick_reg != '0) begin
                    data_next[42 +: VX_W]  = edge_rdata[LO_B +: VX_W];
                    data_next[52 +: VX_W]  = edge_rdata[HI_B +: VX_W];
                    data_next[62 +: TRI_W] = fw_out;
                    data_next[76 +: TRI_W] = rv_out;
                end
            end
            default: stat_next = ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            data_reg <= data_next;
            stat_reg <= stat_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_status = stat_reg;

endmodule

FILE: src/mesh_edge_table_builder_core.sv
// ----------------------------------------------------------------------------
// mesh_edge_table_builder_core
// Triangle mesh edge table builder with a stream input and result channel.
// ----------------------------------------------------------------------------
// Flow from accept to m_tvalid: every item passes dispatch; a clear then sweeps
// the chain heads (one chain head cleared per cycle), a read passes a read state,
// an add walks the chain of each edge, comparing entries, then appends or updates;
// no-op and rejected add go straight to finish. A waiting result stalls the finish.
// One item at a time: the next transfer is taken in the cycle after the result loads.
// Reset: aresetn (synchronous) runs the head sweep, s_tready low, to the last head.
module mesh_edge_table_builder_core import metb_pkg::*; #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_EDGES     = 4096,
    parameter int MAX_TRIANGLES = 2048
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // corner_a[9:0], corner_b[19:10], corner_c[29:20], edge_pick[41:30]
    input  logic [S_DATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // edge_ab[12:0], edge_bc[25:13], edge_ca[38:26], new_mask[41:39],
    // low_vertex[51:42], high_vertex[61:52], forward_tri[75:62],
    // reverse_tri[89:76], edge_total[102:90]
    output logic [M_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]          m_tuser
);

    cmd_t cmd;
    sts_t sts;

    // Controller.
    metb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    metb_dp #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_EDGES     (MAX_EDGES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_data    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

endmodule

FILE: src/metb_checker.sv
// ----------------------------------------------------------------------------
// metb_checker
// Port-level checks of the edge table builder, bound to the top level.
// ----------------------------------------------------------------------------
module metb_checker import metb_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [1:0]          m_tuser
);

    // A stalled result transfer holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The dummy edge is always counted.
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[102:90] != 13'd0)
        else $error("edge total is zero");

    // A read of an unwritten edge returns no read fields.
    a_unwritten: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_NOT_WRIT |-> m_tdata[89:0] == 90'd0)
        else $error("unwritten read carries data");

    // A rejected add returns no edges.
    a_trilim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_TRI_LIM |-> m_tdata[89:0] == 90'd0)
        else $error("triangle limit result carries edges");

    // Reset drops any pending result.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mesh_edge_table_builder_core metb_checker u_metb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/mesh_edge_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_edge_table_checker
// Watches both stream channels of the edge table builder, keeps its own
// copy of the edge table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module mesh_edge_table_checker import metb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic [1:0]          m_tuser,
    output int                  fail_count,
    output int                  pending_count,
    output int                  result_count
);

    localparam int NVX  = 1024;
    localparam int NEDG = 4096;
    localparam int NTRI = 2048;

    // Members run from the highest bit down, matching {m_tdata, m_tuser}.
    typedef struct packed {
        logic [EDGE_W-1:0] edge_total;
        logic [TRI_W-1:0]  reverse_tri;
        logic [TRI_W-1:0]  forward_tri;
        logic [VX_W-1:0]   high_vertex;
        logic [VX_W-1:0]   low_vertex;
        logic [2:0]        new_mask;
        logic [EDGE_W-1:0] edge_ca;
        logic [EDGE_W-1:0] edge_bc;
        logic [EDGE_W-1:0] edge_ab;
        logic [1:0]        status;
    } edge_result_t;

    // Shadow copy of the edge table.
    int unsigned chain_head [NVX];
    int unsigned chain_next [NEDG];
    int unsigned lo_vx      [NEDG];
    int unsigned hi_vx      [NEDG];
    int          fwd_tri    [NEDG];
    int          rev_tri    [NEDG];
    int unsigned edge_cnt;
    int unsigned tri_pos;

    edge_result_t expected_results[$];

    function automatic void clear_table();
        foreach (chain_head[i]) chain_head[i] = 0;
        foreach (chain_next[i]) begin
            chain_next[i] = 0; lo_vx[i] = 0; hi_vx[i] = 0;
            fwd_tri[i] = 0; rev_tri[i] = 0;
        end
        edge_cnt = 1;
        tri_pos  = 0;
    endfunction

    // Finds or appends one edge and returns its signed number.
    function automatic logic [EDGE_W-1:0] lookup_edge(int unsigned p, int unsigned q,
            int unsigned pos, output bit fresh, inout bit full);
        int unsigned lo, hi, e;
        bit fwd;
        lo = (p <= q) ? p : q;
        hi = (p <= q) ? q : p;
        fwd = (p <= q);
        e = chain_head[lo];
        fresh = 0;
        while (e != 0 && !(lo_vx[e] == lo && hi_vx[e] == hi)) e = chain_next[e];
        if (e == 0) begin
            if (edge_cnt >= NEDG) begin
                full = 1;
                return '0;
            end
            e = edge_cnt++;
            lo_vx[e] = lo; hi_vx[e] = hi;
            fwd_tri[e] = -1; rev_tri[e] = -1;
            chain_next[e] = chain_head[lo];
            chain_head[lo] = e;
            fresh = 1;
        end
        if (fwd) begin
            fwd_tri[e] = pos;
            return EDGE_W'(e);
        end
        rev_tri[e] = pos;
        return EDGE_W'(-int'(e));
    endfunction

    function automatic edge_result_t predict_edges(logic [1:0] op, logic [S_DATA_W-1:0] d);
        edge_result_t r;
        bit fresh, full;
        int unsigned pick;
        r = '0;
        full = 0;
        pick = d[41:30];
        case (op)
            OP_CLEAR: clear_table();
            OP_ADD: begin
                if (tri_pos / 3 >= NTRI) begin
                    r.status = ST_TRI_LIM;
                end else begin
                    r.edge_ab = lookup_edge(d[9:0], d[19:10], tri_pos, fresh, full);
                    r.new_mask[0] = fresh;
                    r.edge_bc = lookup_edge(d[19:10], d[29:20], tri_pos, fresh, full);
                    r.new_mask[1] = fresh;
                    r.edge_ca = lookup_edge(d[29:20], d[9:0], tri_pos, fresh, full);
                    r.new_mask[2] = fresh;
                    tri_pos += 3;
                    if (full) r.status = ST_FULL;
                end
            end
            OP_READ: begin
                if (pick >= edge_cnt) begin
                    r.status = ST_NOT_WRIT;
                end else begin
                    r.low_vertex  = VX_W'(lo_vx[pick]);
                    r.high_vertex = VX_W'(hi_vx[pick]);
                    r.forward_tri = TRI_W'(fwd_tri[pick]);
                    r.reverse_tri = TRI_W'(rev_tri[pick]);
                end
            end
            default: ;
        endcase
        r.edge_total = EDGE_W'(edge_cnt);
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 result_count, field, got, want);
        fail_count++;
    endtask

    initial begin
        clear_table();
        fail_count = 0;
        result_count = 0;
    end

    assign pending_count = expected_results.size();

    // Predict on each input transfer, compare on each result transfer.
    always @(posedge aclk) begin
        edge_result_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_results = {expected_results, predict_edges(s_tuser, s_tdata)};
            if (m_tvalid && m_tready) begin
                got = {m_tdata[102:0], m_tuser};
                if (expected_results.size() == 0) begin
                    $display("MISMATCH result %0d arrived with nothing expected",
                             result_count);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.edge_ab != want.edge_ab)
                        report_mismatch("edge_ab", got.edge_ab, want.edge_ab);
                    if (got.edge_bc != want.edge_bc)
                        report_mismatch("edge_bc", got.edge_bc, want.edge_bc);
                    if (got.edge_ca != want.edge_ca)
                        report_mismatch("edge_ca", got.edge_ca, want.edge_ca);
                    if (got.new_mask != want.new_mask)
                        report_mismatch("new_mask", got.new_mask, want.new_mask);
                    if (got.low_vertex != want.low_vertex)
                        report_mismatch("low_vertex", got.low_vertex, want.low_vertex);
                    if (got.high_vertex != want.high_vertex)
                        report_mismatch("high_vertex", got.high_vertex, want.high_vertex);
                    if (got.forward_tri != want.forward_tri)
                        report_mismatch("forward_tri", got.forward_tri, want.forward_tri);
                    if (got.reverse_tri != want.reverse_tri)
                        report_mismatch("reverse_tri", got.reverse_tri, want.reverse_tri);
                    if (got.edge_total != want.edge_total)
                        report_mismatch("edge_total", got.edge_total, want.edge_total);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                end
                result_count++;
            end
        end
    end

endmodule

FILE: tb/mesh_edge_table_builder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_edge_table_builder_core_test
// Drives clear, add, read and no-op items into the edge table builder with
// random idling on both channels; a checker beside the block predicts and
// compares every result. Covers table-full and triangle-limit conditions.
// ----------------------------------------------------------------------------
module mesh_edge_table_builder_core_test;
    import metb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                s_tvalid = 0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]          s_tuser = OP_NOP;
    logic                m_tvalid;
    logic                m_tready = 0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    int                  fail_count, pending_count, result_count;

    bit sink_idle_enable = 1;
    bit src_idle_enable  = 1;
    int idle_cycles = 0;
    int mesh_vx_range = 63;
    int edge_hint = 1;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    mesh_edge_table_builder_core u_top (.*);

    mesh_edge_table_checker u_chk (.*);

    // Watchdog on cycles with no transfer at all.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side readiness with random bursts of back-pressure.
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (sink_idle_enable && $urandom_range(0, 9) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1;
        end
    end

    // One input transfer; idles first now and then. Valid stays high after
    // the transfer so that back-to-back items need only one assignment.
    task automatic send_item(logic [1:0] op, logic [9:0] a, logic [9:0] b,
                             logic [9:0] c, logic [11:0] pick);
        if (src_idle_enable && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, pick, c, b, a};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_item();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            send_item(OP_ADD, 10'($urandom_range(0, mesh_vx_range)),
                      10'($urandom_range(0, mesh_vx_range)),
                      10'($urandom_range(0, mesh_vx_range)), 12'($urandom));
        else if (k < 90)
            send_item(OP_READ, 10'($urandom), 10'($urandom), 10'($urandom),
                      12'($urandom_range(0, edge_hint + 8)));
        else if (k < 97)
            send_item(OP_NOP, 10'($urandom), 10'($urandom), 10'($urandom),
                      12'($urandom));
        else
            send_item(OP_CLEAR, 10'($urandom), 10'($urandom), 10'($urandom),
                      12'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // Directed: extremes, shared edges, degenerate triangles, reads.
        send_item(OP_READ, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 12'hFFF);
        send_item(OP_ADD, 0, 1, 2, 0);
        send_item(OP_ADD, 2, 1, 3, 0);
        send_item(OP_ADD, 1, 2, 4, 0);
        send_item(OP_ADD, 1023, 1023, 1023, 0);
        send_item(OP_ADD, 1023, 0, 512, 12'hFFF);
        send_item(OP_ADD, 5, 5, 6, 0);
        for (int i = 1; i < 12; i++) send_item(OP_READ, 0, 0, 0, 12'(i));
        send_item(OP_NOP, 10'h3FF, 10'h3FF, 10'h3FF, 12'hFFF);
        send_item(OP_CLEAR, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 1);
        send_item(OP_ADD, 7, 8, 9, 0);

        // Hold off until everything has come back.
        s_tvalid <= 0;
        @(posedge aclk);
        wait (pending_count == 0);

        // Random, with a small vertex range in the first half so edges are shared often.
        for (int i = 0; i < 40; i++) begin
            if (i % 20 == 0) mesh_vx_range = (i / 20 % 2) ? 1023 : 40;
            edge_hint = 400;
            send_random_item();
        end

        // Fill the edge table with fresh triangles until it is full.
        send_item(OP_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 1400; i++)
            send_item(OP_ADD, 10'((3 * i) % 1024), 10'((3 * i + 1) % 1024),
                      10'((i / 341 * 7 + 3 * i + 2) % 1024), 0);

        // Last part without idling: run into the triangle limit.
        src_idle_enable  = 0;
        sink_idle_enable = 0;
        for (int i = 0; i < 650; i++)
            send_item(OP_ADD, 10'($urandom_range(0, 30)), 10'($urandom_range(0, 30)),
                      10'($urandom_range(0, 30)), 0);
        send_item(OP_READ, 0, 0, 0, 4095);
        send_item(OP_READ, 0, 0, 0, 4094);
        send_item(OP_CLEAR, 0, 0, 0, 0);
        mesh_vx_range = 20;
        edge_hint = 60;
        for (int i = 0; i < 10; i++) send_random_item();

        s_tvalid <= 0;
        @(posedge aclk);
        wait (pending_count == 0);
        repeat (2000) @(posedge aclk);
        $display("Covered clear, add, read and no-op items, shared and reversed edges,");
        $display("table-full and triangle-limit conditions; %0d results checked.",
                 result_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
src/metb_pkg.sv
src/metb_ram.sv
src/metb_ctrl.sv
src/metb_dp.sv
src/mesh_edge_table_builder_core.sv
src/metb_checker.sv
tb/mesh_edge_table_checker.sv
tb/mesh_edge_table_builder_core_test.sv
